/* hw/rtl/lru_pr_pkg.sv */
// lru page replacement: shared constants and controller/datapath types
// used by lru_pr_ctrl, lru_pr_dp and lru_page_replacement
`default_nettype none

package lru_pr_pkg;

    localparam int unsigned MAX_FRAMES = 16;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned RANK_W     = 4;
    localparam int unsigned CFG_W      = 5;
    localparam int unsigned PAGE_W     = 16;
    localparam int unsigned CNT_W      = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(MAX_FRAMES);

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lru_pr_ctrl.sv */
// lru page replacement: controller state machine
// depends on lru_pr_pkg
`default_nettype none

module lru_pr_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire lru_pr_pkg::dp_status_t status,
    output lru_pr_pkg::dp_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.lookup  = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!status.out_blocked) begin
                    cmd.update = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LOOKUP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lru_pr_dp.sv */
// lru page replacement: frame table, recency ranks, totals and output word
// depends on lru_pr_pkg
`default_nettype none

module lru_pr_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lru_pr_pkg::dp_cmd_t                 cmd,
    output lru_pr_pkg::dp_status_t                   status,
    input  wire logic                                cfg_valid,
    input  wire logic [lru_pr_pkg::CFG_W-1:0]        cfg_frames_in_use,
    input  wire logic [lru_pr_pkg::PAGE_W-1:0]       s_page_number,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_was_hit,
    output logic [lru_pr_pkg::IDX_W-1:0]             m_slot_index,
    output logic [lru_pr_pkg::CNT_W-1:0]             m_fault_total,
    output logic [lru_pr_pkg::CNT_W-1:0]             m_hit_total
);

    localparam int unsigned NF = lru_pr_pkg::MAX_FRAMES;

    logic [lru_pr_pkg::CFG_W-1:0]  frames_reg;
    logic [lru_pr_pkg::PAGE_W-1:0] page_reg;
    logic [lru_pr_pkg::PAGE_W-1:0] store_reg [NF];
    logic [NF-1:0]                 valid_reg;
    logic [lru_pr_pkg::RANK_W-1:0] rank_reg  [NF];
    logic [lru_pr_pkg::CNT_W-1:0]  fault_reg;
    logic [lru_pr_pkg::CNT_W-1:0]  hit_cnt_reg;

    logic                          hit_reg;
    logic                          was_valid_reg;
    logic [lru_pr_pkg::IDX_W-1:0]  slot_reg;
    logic [lru_pr_pkg::RANK_W-1:0] old_rank_reg;

    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [lru_pr_pkg::IDX_W-1:0]  out_slot_reg;

    logic [lru_pr_pkg::CFG_W-1:0]  n_eff;
    logic [NF-1:0]                 active;
    logic [NF-1:0]                 match;
    logic [NF-1:0]                 empty;
    logic [NF-1:0]                 match_first;
    logic [NF-1:0]                 empty_first;
    logic [NF-1:0]                 lru_hot;
    logic [NF-1:0]                 pick;
    logic [lru_pr_pkg::IDX_W-1:0]  pick_idx;
    logic                          any_match;
    logic                          any_empty;
    logic [lru_pr_pkg::CNT_W-1:0]  fault_next;
    logic [lru_pr_pkg::CNT_W-1:0]  hit_cnt_next;

    // clamp the active frame count to 1..MAX_FRAMES
    always_comb begin
        if (frames_reg == '0) begin
            n_eff = lru_pr_pkg::CFG_W'(1);
        end else if (frames_reg > lru_pr_pkg::FRAMES_RESET) begin
            n_eff = lru_pr_pkg::FRAMES_RESET;
        end else begin
            n_eff = frames_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            active[i] = (lru_pr_pkg::CFG_W'(i) < n_eff);
            match[i]  = active[i] && valid_reg[i] && (store_reg[i] == page_reg);
            empty[i]  = active[i] && !valid_reg[i];
        end
    end

    // lowest set bit of each vector
    assign match_first = match & (~match + NF'(1));
    assign empty_first = empty & (~empty + NF'(1));
    assign any_match   = |match;
    assign any_empty   = |empty;

    // valid ranks are distinct, so the oldest active frame is unique
    always_comb begin
        for (int i = 0; i < NF; i++) begin
            lru_hot[i] = active[i];
            for (int j = 0; j < NF; j++) begin
                if (active[j] && (rank_reg[j] > rank_reg[i])) begin
                    lru_hot[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (any_match) begin
            pick = match_first;
        end else if (any_empty) begin
            pick = empty_first;
        end else begin
            pick = lru_hot;
        end
        pick_idx = '0;
        for (int i = 0; i < NF; i++) begin
            if (pick[i]) begin
                pick_idx = pick_idx | lru_pr_pkg::IDX_W'(i);
            end
        end
    end

    // saturating totals
    always_comb begin
        fault_next   = fault_reg;
        hit_cnt_next = hit_cnt_reg;
        if (hit_reg) begin
            if (hit_cnt_reg != '1) begin
                hit_cnt_next = hit_cnt_reg + lru_pr_pkg::CNT_W'(1);
            end
        end else begin
            if (fault_reg != '1) begin
                fault_next = fault_reg + lru_pr_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg    <= lru_pr_pkg::FRAMES_RESET;
            valid_reg     <= '0;
            fault_reg     <= '0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NF; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                frames_reg <= cfg_frames_in_use;
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.update) begin
                for (int i = 0; i < NF; i++) begin
                    if (lru_pr_pkg::IDX_W'(i) == slot_reg) begin
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i]
                                 && (!was_valid_reg || (rank_reg[i] < old_rank_reg))) begin
                        rank_reg[i] <= rank_reg[i] + lru_pr_pkg::RANK_W'(1);
                    end
                end
                valid_reg[slot_reg] <= 1'b1;
                fault_reg           <= fault_next;
                hit_cnt_reg         <= hit_cnt_next;
                out_valid_reg       <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            page_reg <= s_page_number;
        end
        if (cmd.lookup) begin
            hit_reg       <= any_match;
            was_valid_reg <= any_match || !any_empty;
            slot_reg      <= pick_idx;
            old_rank_reg  <= rank_reg[pick_idx];
        end
        if (cmd.update) begin
            if (!hit_reg) begin
                store_reg[slot_reg] <= page_reg;
            end
            out_hit_reg  <= hit_reg;
            out_slot_reg <= slot_reg;
        end
    end

    assign status.out_blocked = out_valid_reg && !m_ready;

    assign m_valid       = out_valid_reg;
    assign m_was_hit     = out_hit_reg;
    assign m_slot_index  = out_slot_reg;
    assign m_fault_total = fault_reg;
    assign m_hit_total   = hit_cnt_reg;

endmodule

`default_nettype wire

/* hw/rtl/lru_page_replacement.sv */
// lru page replacement top level: controller plus datapath
// one word in, one result word out; depends on lru_pr_pkg, lru_pr_ctrl, lru_pr_dp
// an accepted word passes the lookup state, then the update state registers its result
// a new word is taken in the update state, not in lookup; update stalls on a held output
// reset: synchronous active-low aresetn empties all frames, clears ranks and totals,
// and sets frames_in_use to 16
`default_nettype none

module lru_page_replacement (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lru_pr_pkg::CFG_W-1:0]     cfg_frames_in_use,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lru_pr_pkg::PAGE_W-1:0]    s_page_number,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_was_hit,
    output logic [lru_pr_pkg::IDX_W-1:0]          m_slot_index,
    output logic [lru_pr_pkg::CNT_W-1:0]          m_fault_total,
    output logic [lru_pr_pkg::CNT_W-1:0]          m_hit_total
);

    lru_pr_pkg::dp_cmd_t    cmd;
    lru_pr_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lru_pr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lru_pr_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_frames_in_use (cfg_frames_in_use),
        .s_page_number     (s_page_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_was_hit         (m_was_hit),
        .m_slot_index      (m_slot_index),
        .m_fault_total     (m_fault_total),
        .m_hit_total       (m_hit_total)
    );

endmodule

`default_nettype wire
